>>> rtl/sbeh_pkg.sv
// sbeh_pkg: shared types and codes for the segment/box edge-hit pipeline.
// Used by sbeh_muldiv and segment_box_edge_hit; depends on nothing.
`default_nettype none

package sbeh_pkg;

   localparam int LANES = 4;

   typedef enum logic [1:0] {
      EDGE_BOTTOM = 2'd0,
      EDGE_LEFT   = 2'd1,
      EDGE_RIGHT  = 2'd2,
      EDGE_TOP    = 2'd3
   } edge_type;

   // status that travels with each quotient
   typedef struct packed {
      logic neg;   // quotient is to be negated
      logic ovf;   // quotient magnitude beyond the computed width
   } div_flag_type;

endpackage

`default_nettype wire

>>> rtl/segment_box_edge_hit.sv
// segment_box_edge_hit: top level, segment against centred box, first edge in fixed order.
// Depends on sbeh_pkg and sbeh_muldiv.
`default_nettype none

// Usage
//   Request: drive the segment ends, box centre and half extents on req_*
//   and raise start; the item is taken at any edge where start is high and
//   busy is low. busy is never raised, so one item can enter every cycle.
//   Response: exactly one result per item, shown for one cycle with
//   rsp_strobe high; the receiver cannot hold it off and none is needed.
//   Throughput: one item per cycle. The pipe depth is set by the
//   divider lanes: a split multiply (two stages) then one restoring
//   quotient bit per stage over COORD_BITS + 3 bits, with three stages
//   in front and three behind. Four lanes run side by side (bottom,
//   left, right, top); the edge order is resolved only at the end, so
//   the first passing edge wins.
//   Reset clears the valid bits along the pipe; items in flight are dropped.
module segment_box_edge_hit #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_box_centre_x,
   input  logic signed [COORD_BITS-1:0] req_box_centre_y,
   input  logic        [COORD_BITS-2:0] req_half_width,
   input  logic        [COORD_BITS-2:0] req_half_height,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic        [1:0]            rsp_edge_res,
   output logic signed [COORD_BITS-1:0] rsp_hit_x,
   output logic signed [COORD_BITS-1:0] rsp_hit_y
);
   import sbeh_pkg::*;

   localparam int W   = COORD_BITS;
   localparam int QB  = W + 3;
   localparam int LAT = QB + 2;
   localparam int CW  = W + 5;   // crossing coordinate width

   typedef struct packed {
      logic signed [W-1:0] sx;
      logic signed [W-1:0] sy;
      logic signed [W:0]   left;
      logic signed [W:0]   right;
      logic signed [W:0]   bottom;
      logic signed [W:0]   top;
      logic                reject;
      logic                dxz;
      logic                dyz;
   } side_type;

   assign busy = 1'b0;

   // stage 1: input capture
   logic                v1_ff;
   logic signed [W-1:0] sx1_ff, sy1_ff, ex1_ff, ey1_ff, cx1_ff, cy1_ff;
   logic        [W-2:0] hw1_ff, hh1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      sx1_ff <= req_start_x;
      sy1_ff <= req_start_y;
      ex1_ff <= req_end_x;
      ey1_ff <= req_end_y;
      cx1_ff <= req_box_centre_x;
      cy1_ff <= req_box_centre_y;
      hw1_ff <= req_half_width;
      hh1_ff <= req_half_height;
   end

   // stage 2: box edges and deltas, exact at W+1 bits
   logic                v2_ff;
   logic signed [W-1:0] sx2_ff, sy2_ff, ex2_ff, ey2_ff;
   logic signed [W:0]   left2_ff, right2_ff, bottom2_ff, top2_ff, dx2_ff, dy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sx2_ff     <= sx1_ff;
      sy2_ff     <= sy1_ff;
      ex2_ff     <= ex1_ff;
      ey2_ff     <= ey1_ff;
      left2_ff   <= $signed({cx1_ff[W-1], cx1_ff}) - $signed({2'b00, hw1_ff});
      right2_ff  <= $signed({cx1_ff[W-1], cx1_ff}) + $signed({2'b00, hw1_ff});
      bottom2_ff <= $signed({cy1_ff[W-1], cy1_ff}) - $signed({2'b00, hh1_ff});
      top2_ff    <= $signed({cy1_ff[W-1], cy1_ff}) + $signed({2'b00, hh1_ff});
      dx2_ff     <= $signed({ex1_ff[W-1], ex1_ff}) - $signed({sx1_ff[W-1], sx1_ff});
      dy2_ff     <= $signed({ey1_ff[W-1], ey1_ff}) - $signed({sy1_ff[W-1], sy1_ff});
   end

   // stage 3: trivial reject, lane operands as magnitude and sign
   logic signed [W:0]   sxe, sye, exe, eye;
   logic signed [W+1:0] a_s [LANES];
   logic signed [W:0]   b_s [LANES];
   logic signed [W:0]   d_s [LANES];
   logic [W+1:0]        a_mag_in [LANES];
   logic [W:0]          b_mag_in [LANES];
   logic [W:0]          d_mag_in [LANES];
   logic                neg_in   [LANES];
   side_type            side_in;

   always_comb begin
      sxe = $signed({sx2_ff[W-1], sx2_ff});
      sye = $signed({sy2_ff[W-1], sy2_ff});
      exe = $signed({ex2_ff[W-1], ex2_ff});
      eye = $signed({ey2_ff[W-1], ey2_ff});
      a_s[EDGE_BOTTOM] = $signed({bottom2_ff[W], bottom2_ff}) - $signed({sye[W], sye});
      a_s[EDGE_LEFT]   = $signed({left2_ff[W], left2_ff})     - $signed({sxe[W], sxe});
      a_s[EDGE_RIGHT]  = $signed({right2_ff[W], right2_ff})   - $signed({sxe[W], sxe});
      a_s[EDGE_TOP]    = $signed({top2_ff[W], top2_ff})       - $signed({sye[W], sye});
      b_s[EDGE_BOTTOM] = dx2_ff;  d_s[EDGE_BOTTOM] = dy2_ff;
      b_s[EDGE_LEFT]   = dy2_ff;  d_s[EDGE_LEFT]   = dx2_ff;
      b_s[EDGE_RIGHT]  = dy2_ff;  d_s[EDGE_RIGHT]  = dx2_ff;
      b_s[EDGE_TOP]    = dx2_ff;  d_s[EDGE_TOP]    = dy2_ff;
      for (int k = 0; k < LANES; k++) begin
         a_mag_in[k] = a_s[k][W+1] ? (W+2)'(-a_s[k]) : a_s[k];
         b_mag_in[k] = b_s[k][W]   ? (W+1)'(-b_s[k]) : b_s[k];
         d_mag_in[k] = d_s[k][W]   ? (W+1)'(-d_s[k]) : d_s[k];
         neg_in[k]   = a_s[k][W+1] ^ b_s[k][W] ^ d_s[k][W];
      end
      side_in.sx     = sx2_ff;
      side_in.sy     = sy2_ff;
      side_in.left   = left2_ff;
      side_in.right  = right2_ff;
      side_in.bottom = bottom2_ff;
      side_in.top    = top2_ff;
      side_in.dxz    = (dx2_ff == '0);
      side_in.dyz    = (dy2_ff == '0);
      side_in.reject = (sxe <= left2_ff && exe <= left2_ff)
                    || (sxe >= right2_ff && exe >= right2_ff)
                    || (sye >= top2_ff && eye >= top2_ff)
                    || (sye <= bottom2_ff && eye <= bottom2_ff);
   end

   logic         v3_ff;
   side_type     side3_ff;
   logic [W+1:0] a_mag3_ff [LANES];
   logic [W:0]   b_mag3_ff [LANES];
   logic [W:0]   d_mag3_ff [LANES];
   logic         neg3_ff   [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      side3_ff  <= side_in;
      a_mag3_ff <= a_mag_in;
      b_mag3_ff <= b_mag_in;
      d_mag3_ff <= d_mag_in;
      neg3_ff   <= neg_in;
   end

   // divider lanes, one per edge
   logic [W+2:0] q_mag [LANES];
   div_flag_type q_flag [LANES];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      sbeh_muldiv #(.COORD_BITS(W)) u_muldiv (
         .clock (clock),
         .a_mag (a_mag3_ff[k]),
         .b_mag (b_mag3_ff[k]),
         .d_mag (d_mag3_ff[k]),
         .neg   (neg3_ff[k]),
         .q_mag (q_mag[k]),
         .flags (q_flag[k])
      );
   end

   // side data and valid bits ride alongside the dividers
   side_type dly_ff  [LAT];
   logic     vdly_ff [LAT];

   always_ff @(posedge clock) begin
      dly_ff[0] <= side3_ff;
      for (int i = 1; i < LAT; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vdly_ff[i] <= 1'b0;
         end
      end else begin
         vdly_ff[0] <= v3_ff;
         for (int i = 1; i < LAT; i++) begin
            vdly_ff[i] <= vdly_ff[i-1];
         end
      end
   end

   side_type sd;
   assign sd = dly_ff[LAT-1];

   // stage 4: signed crossing coordinates
   logic signed [W+3:0] qs [LANES];
   logic signed [CW-1:0] coord_in [LANES];
   logic                 ovf_in   [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         qs[k] = $signed({1'b0, q_mag[k]});
         if (q_flag[k].neg) begin
            qs[k] = -qs[k];
         end
         ovf_in[k] = q_flag[k].ovf;
      end
      coord_in[EDGE_BOTTOM] = $signed({{5{sd.sx[W-1]}}, sd.sx})
                            + $signed({qs[EDGE_BOTTOM][W+3], qs[EDGE_BOTTOM]});
      coord_in[EDGE_TOP]    = $signed({{5{sd.sx[W-1]}}, sd.sx})
                            + $signed({qs[EDGE_TOP][W+3], qs[EDGE_TOP]});
      coord_in[EDGE_LEFT]   = $signed({{5{sd.sy[W-1]}}, sd.sy})
                            + $signed({qs[EDGE_LEFT][W+3], qs[EDGE_LEFT]});
      coord_in[EDGE_RIGHT]  = $signed({{5{sd.sy[W-1]}}, sd.sy})
                            + $signed({qs[EDGE_RIGHT][W+3], qs[EDGE_RIGHT]});
      // vertical segment: crossing x is the start x
      if (sd.dxz) begin
         coord_in[EDGE_BOTTOM] = $signed({{5{sd.sx[W-1]}}, sd.sx});
         coord_in[EDGE_TOP]    = $signed({{5{sd.sx[W-1]}}, sd.sx});
         ovf_in[EDGE_BOTTOM]   = 1'b0;
         ovf_in[EDGE_TOP]      = 1'b0;
      end
   end

   logic                 v4_ff;
   side_type             side4_ff;
   logic signed [CW-1:0] coord4_ff [LANES];
   logic                 ovf4_ff   [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= vdly_ff[LAT-1];
      end
      side4_ff  <= sd;
      coord4_ff <= coord_in;
      ovf4_ff   <= ovf_in;
   end

   // stage 5: open-span test per edge
   logic signed [CW-1:0] l5, r5, b5, t5;
   logic                 pass_in [LANES];

   always_comb begin
      l5 = $signed({{4{side4_ff.left[W]}},   side4_ff.left});
      r5 = $signed({{4{side4_ff.right[W]}},  side4_ff.right});
      b5 = $signed({{4{side4_ff.bottom[W]}}, side4_ff.bottom});
      t5 = $signed({{4{side4_ff.top[W]}},    side4_ff.top});
      pass_in[EDGE_BOTTOM] = !side4_ff.dyz && !ovf4_ff[EDGE_BOTTOM]
                          && coord4_ff[EDGE_BOTTOM] > l5 && coord4_ff[EDGE_BOTTOM] < r5;
      pass_in[EDGE_LEFT]   = !side4_ff.dxz && !ovf4_ff[EDGE_LEFT]
                          && coord4_ff[EDGE_LEFT] < t5 && coord4_ff[EDGE_LEFT] > b5;
      pass_in[EDGE_RIGHT]  = !side4_ff.dxz && !ovf4_ff[EDGE_RIGHT]
                          && coord4_ff[EDGE_RIGHT] < t5 && coord4_ff[EDGE_RIGHT] > b5;
      pass_in[EDGE_TOP]    = !side4_ff.dyz && !ovf4_ff[EDGE_TOP]
                          && coord4_ff[EDGE_TOP] > l5 && coord4_ff[EDGE_TOP] < r5;
      for (int k = 0; k < LANES; k++) begin
         pass_in[k] = pass_in[k] && !side4_ff.reject;
      end
   end

   logic                 v5_ff;
   side_type             side5_ff;
   logic signed [CW-1:0] coord5_ff [LANES];
   logic                 pass5_ff  [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      side5_ff  <= side4_ff;
      coord5_ff <= coord4_ff;
      pass5_ff  <= pass_in;
   end

   // stage 6: first passing edge in fixed order, saturate to output width
   logic signed [CW-1:0] hx_w, hy_w;
   logic                 hit_in;
   edge_type             edge_in;
   logic signed [W-1:0]  hx_in, hy_in;
   logic signed [W-1:0]  sat_max, sat_min;

   always_comb begin
      hit_in  = 1'b1;
      edge_in = EDGE_BOTTOM;
      hx_w    = '0;
      hy_w    = '0;
      priority if (pass5_ff[EDGE_BOTTOM]) begin
         edge_in = EDGE_BOTTOM;
         hx_w    = coord5_ff[EDGE_BOTTOM];
         hy_w    = $signed({{4{side5_ff.bottom[W]}}, side5_ff.bottom});
      end else if (pass5_ff[EDGE_LEFT]) begin
         edge_in = EDGE_LEFT;
         hx_w    = $signed({{4{side5_ff.left[W]}}, side5_ff.left});
         hy_w    = coord5_ff[EDGE_LEFT];
      end else if (pass5_ff[EDGE_RIGHT]) begin
         edge_in = EDGE_RIGHT;
         hx_w    = $signed({{4{side5_ff.right[W]}}, side5_ff.right});
         hy_w    = coord5_ff[EDGE_RIGHT];
      end else if (pass5_ff[EDGE_TOP]) begin
         edge_in = EDGE_TOP;
         hx_w    = coord5_ff[EDGE_TOP];
         hy_w    = $signed({{4{side5_ff.top[W]}}, side5_ff.top});
      end else begin
         hit_in  = 1'b0;
      end
      sat_max = $signed({1'b0, {(W-1){1'b1}}});
      sat_min = $signed({1'b1, {(W-1){1'b0}}});
      if (hx_w[CW-1:W-1] == '0 || hx_w[CW-1:W-1] == '1) begin
         hx_in = hx_w[W-1:0];
      end else begin
         hx_in = hx_w[CW-1] ? sat_min : sat_max;
      end
      if (hy_w[CW-1:W-1] == '0 || hy_w[CW-1:W-1] == '1) begin
         hy_in = hy_w[W-1:0];
      end else begin
         hy_in = hy_w[CW-1] ? sat_min : sat_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= v5_ff;
      end
      rsp_hit      <= hit_in;
      rsp_edge_res <= edge_in;
      rsp_hit_x    <= hx_in;
      rsp_hit_y    <= hy_in;
   end

endmodule

`default_nettype wire

>>> rtl/sbeh_muldiv.sv
// sbeh_muldiv: pipelined trunc(|a|*|b|/|d|), split multiply then one quotient bit a stage.
// Depends on sbeh_pkg.
`default_nettype none

module sbeh_muldiv #(
   parameter int COORD_BITS = 32
) (
   input  logic                   clock,
   input  logic [COORD_BITS+1:0]  a_mag,
   input  logic [COORD_BITS:0]    b_mag,
   input  logic [COORD_BITS:0]    d_mag,
   input  logic                   neg,
   output logic [COORD_BITS+2:0]  q_mag,
   output sbeh_pkg::div_flag_type flags
);
   import sbeh_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int AW = W + 2;
   localparam int BW = W + 1;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;
   localparam int QB = W + 3;
   localparam int WW = W + 1 + QB;

   logic [AW+BL-1:0] pl_ff;
   logic [AW+BH-1:0] ph_ff;
   logic [W:0]       d1_ff;
   logic             neg1_ff;

   always_ff @(posedge clock) begin
      pl_ff   <= a_mag * b_mag[BL-1:0];
      ph_ff   <= a_mag * b_mag[BW-1:BL];
      d1_ff   <= d_mag;
      neg1_ff <= neg;
   end

   logic [PW-1:0]  prod;
   logic [WW-1:0]  work_ff [QB+1];
   logic [W:0]     d_ff    [QB+1];
   div_flag_type   flag_ff [QB+1];
   div_flag_type   flag0;

   always_comb begin
      prod      = {{BH{1'b0}}, pl_ff} + {ph_ff, {BL{1'b0}}};
      flag0.neg = neg1_ff;
      flag0.ovf = ({1'b0, prod[PW-1:QB]} >= d1_ff);
   end

   always_ff @(posedge clock) begin
      work_ff[0] <= {1'b0, prod};
      d_ff[0]    <= d1_ff;
      flag_ff[0] <= flag0;
   end

   for (genvar j = 0; j < QB; j++) begin : g_step
      logic [W+1:0] cand;
      logic [W+1:0] diff;
      logic         ge;
      always_comb begin
         cand = {work_ff[j][WW-1:QB], work_ff[j][QB-1]};
         diff = cand - {1'b0, d_ff[j]};
         ge   = (cand >= {1'b0, d_ff[j]});
      end
      always_ff @(posedge clock) begin
         work_ff[j+1] <= {(ge ? diff[W:0] : cand[W:0]), work_ff[j][QB-2:0], ge};
         d_ff[j+1]    <= d_ff[j];
         flag_ff[j+1] <= flag_ff[j];
      end
   end

   assign q_mag = work_ff[QB][QB-1:0];
   assign flags = flag_ff[QB];

endmodule

`default_nettype wire
